>>> design/tme_pkg.sv
// ----------------------------------------------------------------------------
// tme_pkg
// shared types and constants of the tape machine execute unit
// ----------------------------------------------------------------------------
package tme_pkg;

  // field widths fixed by the instruction format
  localparam int unsigned OP_W     = 3;
  localparam int unsigned AMOUNT_W = 16;
  localparam int unsigned BYTE_W   = 8;

  // default configuration
  localparam int unsigned TAPE_DEPTH_DEF = 32768;
  localparam int unsigned PC_WIDTH_DEF   = 16;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 3'd0,
    OP_MOVE   = 3'd1,
    OP_JZ     = 3'd2,
    OP_JNZ    = 3'd3,
    OP_SET    = 3'd4,
    OP_MULADD = 3'd5,
    OP_OUTPUT = 3'd6,
    OP_INPUT  = 3'd7
  } op_e;

  // control flags from the execute logic to the pipeline
  typedef struct packed {
    logic we;    // instruction writes a tape cell
    logic emit;  // instruction produces an output byte
  } exec_flags_t;

endpackage

>>> design/tme_if.sv
// ----------------------------------------------------------------------------
// tme_if
// request and result channels of the tape machine execute unit
// ----------------------------------------------------------------------------
interface tme_req_if #(
  parameter int unsigned PC_WIDTH = tme_pkg::PC_WIDTH_DEF
);
  logic                                valid;
  logic                                ready;
  logic [tme_pkg::OP_W-1:0]            op;
  logic signed [tme_pkg::AMOUNT_W-1:0] amount;
  logic [tme_pkg::BYTE_W-1:0]          factor;
  logic [PC_WIDTH-1:0]                 pc;
  logic [PC_WIDTH-1:0]                 jump_target;
  logic [tme_pkg::BYTE_W-1:0]          in_byte;

  modport source (
    output valid, op, amount, factor, pc, jump_target, in_byte,
    input  ready
  );
  modport sink (
    input  valid, op, amount, factor, pc, jump_target, in_byte,
    output ready
  );
endinterface

interface tme_rsp_if #(
  parameter int unsigned PC_WIDTH = tme_pkg::PC_WIDTH_DEF
);
  logic                       valid;
  logic                       ready;
  logic [PC_WIDTH-1:0]        next_pc;
  logic                       out_valid;
  logic [tme_pkg::BYTE_W-1:0] out_byte;

  modport source (
    output valid, next_pc, out_valid, out_byte,
    input  ready
  );
  modport sink (
    input  valid, next_pc, out_valid, out_byte,
    output ready
  );
endinterface

>>> design/tme_tape_ram.sv
// ----------------------------------------------------------------------------
// tme_tape_ram
// one copy of the tape: synchronous ram with write-to-read forwarding
// ----------------------------------------------------------------------------
module tme_tape_ram #(
  parameter int unsigned TAPE_DEPTH = tme_pkg::TAPE_DEPTH_DEF,
  localparam int unsigned AW = $clog2(TAPE_DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [tme_pkg::BYTE_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [tme_pkg::BYTE_W-1:0] rdata_o
);

  logic [tme_pkg::BYTE_W-1:0] mem [TAPE_DEPTH];
  logic [tme_pkg::BYTE_W-1:0] rd_q;
  logic [tme_pkg::BYTE_W-1:0] fwd_data_q;
  logic                       fwd_q;

  // read returns old data on a collision, so the written byte is forwarded
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q       <= mem[raddr_i];
      fwd_data_q <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (re_i) begin
      fwd_q <= we_i && (waddr_i == raddr_i);
    end
  end

  assign rdata_o = fwd_q ? fwd_data_q : rd_q;

endmodule

>>> design/tme_clear.sv
// ----------------------------------------------------------------------------
// tme_clear
// post-reset sweep that writes zero to every tape cell
// ----------------------------------------------------------------------------
module tme_clear #(
  parameter int unsigned TAPE_DEPTH = tme_pkg::TAPE_DEPTH_DEF,
  localparam int unsigned AW = $clog2(TAPE_DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  output logic          busy_o,
  output logic [AW-1:0] addr_o
);

  logic          busy_q, busy_d;
  logic [AW-1:0] cnt_q, cnt_d;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (busy_q) begin
      cnt_d = cnt_q + AW'(1);
      if (cnt_q == {AW{1'b1}}) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  assign busy_o = busy_q;
  assign addr_o = cnt_q;

endmodule

>>> design/tme_exec.sv
// ----------------------------------------------------------------------------
// tme_exec
// per-instruction cell update, branch decision and output byte
// ----------------------------------------------------------------------------
module tme_exec #(
  parameter int unsigned PC_WIDTH = tme_pkg::PC_WIDTH_DEF
) (
  input  tme_pkg::op_e                op_i,
  input  logic [tme_pkg::BYTE_W-1:0]  amount_lo_i,
  input  logic [tme_pkg::BYTE_W-1:0]  factor_i,
  input  logic [tme_pkg::BYTE_W-1:0]  in_byte_i,
  input  logic [PC_WIDTH-1:0]         pc_i,
  input  logic [PC_WIDTH-1:0]         jump_target_i,
  input  logic [tme_pkg::BYTE_W-1:0]  cell_cur_i,  // cell under the pointer
  input  logic [tme_pkg::BYTE_W-1:0]  cell_dst_i,  // old value of the written cell
  output tme_pkg::exec_flags_t        flags_o,
  output logic [tme_pkg::BYTE_W-1:0]  wdata_o,
  output logic [PC_WIDTH-1:0]         next_pc_o,
  output logic [tme_pkg::BYTE_W-1:0]  out_byte_o
);

  localparam int unsigned PW = 2 * tme_pkg::BYTE_W;

  logic [PW-1:0] prod;
  logic          taken;
  logic          cur_zero;

  assign prod     = {{tme_pkg::BYTE_W{1'b0}}, cell_cur_i} *
                    {{tme_pkg::BYTE_W{1'b0}}, factor_i};
  assign cur_zero = (cell_cur_i == '0);

  always_comb begin
    flags_o    = '0;
    wdata_o    = '0;
    taken      = 1'b0;
    out_byte_o = '0;
    case (op_i)
      tme_pkg::OP_ADD: begin
        flags_o.we = 1'b1;
        wdata_o    = cell_dst_i + amount_lo_i;
      end
      tme_pkg::OP_MOVE: begin
        flags_o.we = 1'b0;
      end
      tme_pkg::OP_JZ: begin
        taken = cur_zero;
      end
      tme_pkg::OP_JNZ: begin
        taken = !cur_zero;
      end
      tme_pkg::OP_SET: begin
        flags_o.we = 1'b1;
        wdata_o    = amount_lo_i;
      end
      tme_pkg::OP_MULADD: begin
        flags_o.we = 1'b1;
        wdata_o    = cell_dst_i + prod[tme_pkg::BYTE_W-1:0];
      end
      tme_pkg::OP_OUTPUT: begin
        flags_o.emit = 1'b1;
        out_byte_o   = cell_cur_i;
      end
      tme_pkg::OP_INPUT: begin
        flags_o.we = 1'b1;
        wdata_o    = in_byte_i;
      end
      default: begin
        flags_o = '0;
      end
    endcase
  end

  assign next_pc_o = (taken ? jump_target_i : pc_i) + PC_WIDTH'(1);

endmodule

>>> design/tape_machine_execute_core.sv
// ----------------------------------------------------------------------------
// tape_machine_execute_core
// execute unit of a byte-tape machine with set and multiply-add operations
// ----------------------------------------------------------------------------
// usage
//   req_i carries one decoded instruction per request (valid/ready); rsp_o
//   returns one result per instruction in order: next pc, an output flag
//   and the output byte (zero unless the instruction is an output).
//   the tape lives in two identical ram copies, each with one write and one
//   read port; the second read port serves the multiply-add destination.
//   flow: a request is read from ram when accepted; it is executed and written
//   back as it leaves the execute stage, which also loads the output register.
//   throughput: one instruction per cycle unless the output stalls; a write
//   in the same cycle as the next read of that cell is forwarded in the ram.
//   the data pointer is updated at acceptance, so back-to-back moves work.
//   reset: pointer goes to zero and a clearing sweep writes zero to every
//   cell, one per cycle; no request is taken until done.
//   stall: while a result waits in the output register one more request can
//   be held in the execute stage; then ready drops until the result leaves.
//   TAPE_DEPTH must be a power of two; the pointer wraps modulo the depth.
// ----------------------------------------------------------------------------
module tape_machine_execute_core #(
  parameter int unsigned TAPE_DEPTH = tme_pkg::TAPE_DEPTH_DEF,
  parameter int unsigned PC_WIDTH   = tme_pkg::PC_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tme_req_if.sink   req_i,
  tme_rsp_if.source rsp_o
);

  localparam int unsigned AW = $clog2(TAPE_DEPTH);
  localparam int unsigned BW = tme_pkg::BYTE_W;

  // clearing sweep
  logic          busy;
  logic [AW-1:0] clr_addr;

  // data pointer
  logic [AW-1:0] dp_q, dp_d;
  logic [AW-1:0] ofs_addr;     // pointer plus signed amount, wrapped
  logic [AW-1:0] dst_addr;     // cell written by this request
  tme_pkg::op_e  req_op;

  // execute stage
  logic                s1_valid_q;
  tme_pkg::op_e        s1_op_q;
  logic [BW-1:0]       s1_amt_q;
  logic [BW-1:0]       s1_factor_q;
  logic [BW-1:0]       s1_in_byte_q;
  logic [PC_WIDTH-1:0] s1_pc_q;
  logic [PC_WIDTH-1:0] s1_target_q;
  logic [AW-1:0]       s1_waddr_q;
  logic                s1_adv;

  // output register
  logic                rsp_valid_q;
  logic [PC_WIDTH-1:0] rsp_pc_q;
  logic                rsp_flag_q;
  logic [BW-1:0]       rsp_byte_q;

  // ram ports
  logic          req_acc;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [BW-1:0] mem_wdata;
  logic [BW-1:0] cell_cur;
  logic [BW-1:0] cell_dst;

  // execute results
  tme_pkg::exec_flags_t flags;
  logic [BW-1:0]        ex_wdata;
  logic [PC_WIDTH-1:0]  ex_next_pc;
  logic [BW-1:0]        ex_byte;

  tme_clear #(.TAPE_DEPTH(TAPE_DEPTH)) u_clear (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .busy_o (busy),
    .addr_o (clr_addr)
  );

  // after the sweep the stage takes a request when empty or draining this cycle
  assign s1_adv      = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = !busy && (!s1_valid_q || s1_adv);
  assign req_acc     = req_i.valid && req_i.ready;

  // pointer arithmetic wraps naturally at a power-of-two depth
  assign req_op   = tme_pkg::op_e'(req_i.op);
  assign ofs_addr = dp_q + req_i.amount[AW-1:0];
  assign dst_addr = (req_op == tme_pkg::OP_MULADD) ? ofs_addr : dp_q;

  always_comb begin
    dp_d = dp_q;
    if (req_acc && (req_op == tme_pkg::OP_MOVE)) begin
      dp_d = ofs_addr;
    end
  end

  // write port: sweep has priority, otherwise the executing request writes
  assign mem_we    = busy || (s1_valid_q && s1_adv && flags.we);
  assign mem_waddr = busy ? clr_addr : s1_waddr_q;
  assign mem_wdata = busy ? '0 : ex_wdata;

  // copy read at the pointer
  tme_tape_ram #(.TAPE_DEPTH(TAPE_DEPTH)) u_ram_cur (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (req_acc),
    .raddr_i (dp_q),
    .rdata_o (cell_cur)
  );

  // copy read at the destination cell
  tme_tape_ram #(.TAPE_DEPTH(TAPE_DEPTH)) u_ram_dst (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (req_acc),
    .raddr_i (dst_addr),
    .rdata_o (cell_dst)
  );

  tme_exec #(.PC_WIDTH(PC_WIDTH)) u_exec (
    .op_i          (s1_op_q),
    .amount_lo_i   (s1_amt_q),
    .factor_i      (s1_factor_q),
    .in_byte_i     (s1_in_byte_q),
    .pc_i          (s1_pc_q),
    .jump_target_i (s1_target_q),
    .cell_cur_i    (cell_cur),
    .cell_dst_i    (cell_dst),
    .flags_o       (flags),
    .wdata_o       (ex_wdata),
    .next_pc_o     (ex_next_pc),
    .out_byte_o    (ex_byte)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dp_q        <= '0;
      s1_valid_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      dp_q <= dp_d;
      if (req_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        rsp_valid_q <= s1_valid_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      s1_op_q      <= req_op;
      s1_amt_q     <= req_i.amount[BW-1:0];
      s1_factor_q  <= req_i.factor;
      s1_in_byte_q <= req_i.in_byte;
      s1_pc_q      <= req_i.pc;
      s1_target_q  <= req_i.jump_target;
      s1_waddr_q   <= dst_addr;
    end
    if (s1_valid_q && s1_adv) begin
      rsp_pc_q   <= ex_next_pc;
      rsp_flag_q <= flags.emit;
      rsp_byte_q <= ex_byte;
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.next_pc   = rsp_pc_q;
  assign rsp_o.out_valid = rsp_flag_q;
  assign rsp_o.out_byte  = rsp_byte_q;

  // no request is taken while the tape is being cleared
  a_no_req_while_clearing: assert property (
    @(posedge clk_i) disable iff (!rst_ni) busy |-> !req_i.ready
  ) else $error("request accepted during clearing sweep");

  // sweep and execute stage never compete for the write port
  a_stage_empty_while_clearing: assert property (
    @(posedge clk_i) disable iff (!rst_ni) busy |-> !s1_valid_q
  ) else $error("execute stage busy during clearing sweep");

  // an accepted request occupies the execute stage next cycle
  a_accept_fills_stage: assert property (
    @(posedge clk_i) disable iff (!rst_ni) req_acc |=> s1_valid_q
  ) else $error("accepted request lost");

  // a result without an output byte carries zero
  a_byte_zero_without_flag: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      rsp_valid_q && !rsp_flag_q |-> (rsp_byte_q == '0)
  ) else $error("output byte set without output flag");

endmodule
